>>> design/sil_pkg.sv
package sil_pkg;

  // Reset value of the load base register.
  localparam logic [31:0] LoadBaseReset = 32'h0008_0000;

  // Default width of the target address space.
  localparam int AddrBitsDefault = 32;

  // Number of entries in the command queue between front and back.
  localparam int QueueDepth = 2;

  // What the back end does with one byte.
  typedef enum logic [1:0] {
    OP_LEN  = 2'd0,
    OP_SUM  = 2'd1,
    OP_DATA = 2'd2
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  data;
    logic        done;
    logic [31:0] index;
  } cmd_t;

endpackage

>>> design/sil_front.sv
module sil_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rx_valid_i,
  output logic          rx_stall_o,
  input  logic [7:0]    rx_byte_i,
  output logic          cmd_push_o,
  output sil_pkg::cmd_t cmd_o,
  input  logic          cmd_full_i
);
  import sil_pkg::*;

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_SUM  = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [31:0] len_q, len_d;
  logic [31:0] index_q, index_d;
  logic [31:0] index_nxt;
  logic [23:0] len_keep;
  logic        accept;

  assign rx_stall_o = cmd_full_i;
  assign accept     = rx_valid_i && !cmd_full_i;
  assign cmd_push_o = accept;
  assign index_nxt  = index_q + 32'd1;
  // The first length byte starts a fresh word.
  assign len_keep   = (hdr_cnt_q == 2'd0) ? 24'd0 : len_q[23:0];

  always_comb begin
    phase_d    = phase_q;
    hdr_cnt_d  = hdr_cnt_q;
    len_d      = len_q;
    index_d    = index_q;
    cmd_o.op    = OP_LEN;
    cmd_o.data  = rx_byte_i;
    cmd_o.done  = 1'b0;
    cmd_o.index = index_q;
    case (phase_q)
      PH_DATA: begin
        cmd_o.op = OP_DATA;
        if (index_nxt == len_q) begin
          cmd_o.done = 1'b1;
          phase_d    = PH_LEN;
          index_d    = 32'd0;
        end else begin
          index_d = index_nxt;
        end
      end
      PH_SUM: begin
        cmd_o.op = OP_SUM;
        if (hdr_cnt_q == 2'd3) begin
          hdr_cnt_d = 2'd0;
          index_d   = 32'd0;
          // An empty or negative length closes the frame right after the header.
          if (len_q == 32'd0 || len_q[31]) begin
            cmd_o.done = 1'b1;
            phase_d    = PH_LEN;
          end else begin
            phase_d = PH_DATA;
          end
        end else begin
          hdr_cnt_d = hdr_cnt_q + 2'd1;
        end
      end
      default: begin
        cmd_o.op = OP_LEN;
        len_d    = {len_keep, rx_byte_i};
        if (hdr_cnt_q == 2'd3) begin
          hdr_cnt_d = 2'd0;
          phase_d   = PH_SUM;
        end else begin
          hdr_cnt_d = hdr_cnt_q + 2'd1;
          phase_d   = PH_LEN;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LEN;
      hdr_cnt_q <= 2'd0;
      len_q     <= 32'd0;
      index_q   <= 32'd0;
    end else if (accept) begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      len_q     <= len_d;
      index_q   <= index_d;
    end
  end

endmodule

>>> design/sil_queue.sv
module sil_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sil_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output sil_pkg::cmd_t pop_cmd_o,
  output logic          empty_o
);
  import sil_pkg::*;

  localparam int PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntBits = $clog2(QueueDepth + 1);

  cmd_t               mem_q [QueueDepth];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] cnt_q;

  assign full_o    = (cnt_q == CntBits'(QueueDepth));
  assign empty_o   = (cnt_q == '0);
  assign pop_cmd_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> design/sil_back.sv
module sil_back #(
  parameter int ADDR_BITS = sil_pkg::AddrBitsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_base_we_i,
  input  logic [31:0]   load_base_i,
  input  sil_pkg::cmd_t cmd_i,
  input  logic          cmd_empty_i,
  output logic          cmd_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          write_enable_o,
  output logic [31:0]   write_address_o,
  output logic [7:0]    write_data_o,
  output logic          frame_done_o,
  output logic          frame_ok_o
);
  import sil_pkg::*;

  // Address bits above the target address space read as zero.
  localparam logic [31:0] AddrMask = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF
                                   : 32'((64'd1 << ADDR_BITS) - 64'd1);

  logic [31:0] base_q;
  logic [31:0] rem_q, rem_d;
  logic        vld_q;
  logic        we_q, we_d;
  logic [31:0] addr_q, addr_d;
  logic [7:0]  data_q, data_d;
  logic        done_q, done_d;
  logic        ok_q, ok_d;
  logic [31:0] addr_sum;

  assign cmd_pop_o = !cmd_empty_i && (!vld_q || !out_stall_i);
  assign addr_sum  = base_q + cmd_i.index;

  always_comb begin
    rem_d  = rem_q;
    we_d   = 1'b0;
    addr_d = 32'd0;
    data_d = 8'd0;
    done_d = 1'b0;
    case (cmd_i.op)
      OP_DATA: begin
        rem_d  = rem_q - {24'd0, cmd_i.data};
        we_d   = 1'b1;
        addr_d = addr_sum & AddrMask;
        data_d = cmd_i.data;
        done_d = cmd_i.done;
      end
      OP_SUM: begin
        // Four header bytes shift the whole expected checksum in.
        rem_d  = {rem_q[23:0], cmd_i.data};
        done_d = cmd_i.done;
      end
      default: begin
        rem_d = rem_q;
      end
    endcase
    ok_d = done_d && (rem_d == 32'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= LoadBaseReset;
      rem_q  <= 32'd0;
      vld_q  <= 1'b0;
    end else begin
      if (load_base_we_i) begin
        base_q <= load_base_i;
      end
      if (cmd_pop_o) begin
        rem_q <= rem_d;
        vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      we_q   <= we_d;
      addr_q <= addr_d;
      data_q <= data_d;
      done_q <= done_d;
      ok_q   <= ok_d;
    end
  end

  assign out_valid_o     = vld_q;
  assign write_enable_o  = we_q;
  assign write_address_o = addr_q;
  assign write_data_o    = data_q;
  assign frame_done_o    = done_q;
  assign frame_ok_o      = ok_q;

endmodule

>>> design/serial_image_loader_frame_core.sv
// Serial image loader frame receiver.
// The rx channel (rx_valid_i, rx_stall_o, rx_byte_i) takes one received byte per beat.
// Every byte yields exactly one beat on the out channel (out_valid_o, out_stall_i):
// header bytes give a beat with write_enable_o low, payload bytes a store request
// at load_base plus the payload index. frame_done_o marks the byte that closes a
// frame, and frame_ok_o tells whether the checksum remainder came out zero.
// Throughput is one byte per cycle while the command queue is not full. A byte accepted
// at a clock edge is written into the command queue, and from there into the output
// register of the checksum and address unit, which presents it on the out channel.
// The front end classifies bytes and tracks the header and payload count; the back
// end holds the checksum remainder, the load base and the output register.
// When the receiver stalls, the output beat holds, the two-entry queue fills and
// rx_stall_o rises only once the queue is full.
// Reset empties the queue and output register, returns to waiting for a length
// header and sets load_base to 0x80000. load_base_i is written whenever
// load_base_we_i is high, and is meant to change only while no frame is active.
module serial_image_loader_frame_core #(
  parameter int ADDR_BITS = sil_pkg::AddrBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_base_we_i,
  input  logic [31:0] load_base_i,
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        write_enable_o,
  output logic [31:0] write_address_o,
  output logic [7:0]  write_data_o,
  output logic        frame_done_o,
  output logic        frame_ok_o
);
  import sil_pkg::*;

  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic push;
  logic pop;
  logic full;
  logic empty;

  sil_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_stall_o (rx_stall_o),
    .rx_byte_i  (rx_byte_i),
    .cmd_push_o (push),
    .cmd_o      (push_cmd),
    .cmd_full_i (full)
  );

  sil_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (empty)
  );

  sil_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_base_we_i  (load_base_we_i),
    .load_base_i     (load_base_i),
    .cmd_i           (pop_cmd),
    .cmd_empty_i     (empty),
    .cmd_pop_o       (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .write_enable_o  (write_enable_o),
    .write_address_o (write_address_o),
    .write_data_o    (write_data_o),
    .frame_done_o    (frame_done_o),
    .frame_ok_o      (frame_ok_o)
  );

endmodule
